>>> hdl/lpi_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpi_pkg
// Shared widths, controller states and the command and status bundles of the
// line path interpolator.
// -----------------------------------------------------------------------------
package lpi_pkg;

	localparam int COORD_W    = 32;
	localparam int MAX_POINTS = 64;
	localparam int N_W        = $clog2(MAX_POINTS);
	localparam int STEP_W     = 31;
	localparam int LEN_W      = COORD_W + 1;
	localparam int SUM_W      = 2 * LEN_W;
	localparam int NUM_W      = 64;
	localparam int NAXES      = 3;
	localparam int IN_W       = 2 * NAXES * COORD_W;
	localparam int OUT_W      = NAXES * COORD_W;
	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

	typedef enum logic [12:0] {
		ST_IDLE    = 13'd1,
		ST_SQR     = 13'd2,
		ST_RT_GO   = 13'd4,
		ST_RT_WAIT = 13'd8,
		ST_ND_GO   = 13'd16,
		ST_ND_WAIT = 13'd32,
		ST_AX_MUL  = 13'd64,
		ST_AX_GO   = 13'd128,
		ST_AX_WAIT = 13'd256,
		ST_E_START = 13'd512,
		ST_STEP    = 13'd1024,
		ST_E_PT    = 13'd2048,
		ST_E_END   = 13'd4096
	} state_t;

	typedef enum logic [1:0] {
		EM_START = 2'd0,
		EM_POINT = 2'd1,
		EM_END   = 2'd2
	} emit_sel_t;

	typedef struct packed {
		logic      load;
		logic      sum_add;
		logic      mul_sq;
		logic [1:0] axis;
		logic      sqrt_start;
		logic      div_start;
		logic      div_n;
		logic      acc_clr;
		logic      acc_step;
		logic      emit;
		emit_sel_t emit_sel;
	} cmd_t;

	typedef struct packed {
		logic           out_free;
		logic           sqrt_done;
		logic           div_done;
		logic           len_zero;
		logic [N_W-1:0] n;
		logic           clip;
		logic           units_busy;
	} status_t;

endpackage

>>> hdl/lpi_sqrt.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpi_sqrt
// Iterative integer square root, one result bit per cycle.
// -----------------------------------------------------------------------------
module lpi_sqrt import lpi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SUM_W-1:0] rad,
	output logic             busy,
	output logic             done,
	output logic [LEN_W-1:0] root
);

	localparam int REM_W = LEN_W + 2;
	localparam int CNT_W = $clog2(LEN_W);

	logic [SUM_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [LEN_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;
	logic             ge;

	assign rem_sh = {rem_q, rad_q[SUM_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign diff   = rem_sh - trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

>>> hdl/lpi_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpi_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module lpi_div import lpi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [LEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [LEN_W-1:0] quo,
	output logic [LEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [LEN_W:0]   rem_sh;
	logic [LEN_W:0]   diff;
	logic             ge;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = num_q[LEN_W-1:0];
	assign rem  = rem_q;

endmodule

>>> hdl/lpi_dp.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpi_dp
// Datapath: segment capture, shared multiplier, square root and divider
// units, per-axis offset accumulators and the output register.
// -----------------------------------------------------------------------------
module lpi_dp import lpi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [STEP_W-1:0] cfg_wr_data,
	input  logic [IN_W-1:0]   in_data,
	input  cmd_t              cmd,
	output status_t           status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [OUT_W-1:0]  out_data,
	output logic              out_last,
	output logic              out_user
);

	logic [STEP_W-1:0]  step_q;
	logic [STEP_W-1:0]  st_eff;
	logic [COORD_W-1:0] s_q [NAXES];
	logic [COORD_W-1:0] e_q [NAXES];
	logic [LEN_W-1:0]   dm_q [NAXES];
	logic               neg_q [NAXES];
	logic [LEN_W-1:0]   dm_in [NAXES];
	logic               neg_in [NAXES];
	logic [LEN_W-1:0]   qt_q [NAXES];
	logic [LEN_W-1:0]   rt_q [NAXES];
	logic [LEN_W-1:0]   off_q [NAXES];
	logic [LEN_W-1:0]   r_q [NAXES];
	logic [COORD_W-1:0] pt [NAXES];
	logic [SUM_W-1:0]   prod_s1;
	logic [SUM_W-1:0]   sum_q;
	logic [LEN_W-1:0]   len_q;
	logic [LEN_W-1:0]   mul_a;
	logic [LEN_W-1:0]   mul_b;
	logic [N_W-1:0]     n_q;
	logic               clip_q;
	logic               sq_busy;
	logic               sq_done;
	logic [LEN_W-1:0]   sq_root;
	logic               dv_busy;
	logic               dv_done;
	logic [NUM_W-1:0]   dv_num;
	logic [LEN_W-1:0]   dv_den;
	logic [LEN_W-1:0]   dv_quo;
	logic [LEN_W-1:0]   dv_rem;
	logic [LEN_W:0]     n_full;
	logic               ov_q;
	logic [OUT_W-1:0]   od_q;
	logic               ol_q;
	logic               ou_q;
	logic               out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
		end else if (cfg_wr_en) begin
			step_q <= cfg_wr_data;
		end
	end

	assign st_eff = (step_q == '0) ? STEP_W'(1) : step_q;

	always_comb begin
		logic [LEN_W-1:0] diff;
		for (int j = 0; j < NAXES; j++) begin
			diff = {in_data[j*COORD_W + COORD_W-1], in_data[j*COORD_W +: COORD_W]}
				- {in_data[(j+NAXES)*COORD_W + COORD_W-1],
				   in_data[(j+NAXES)*COORD_W +: COORD_W]};
			neg_in[j] = diff[LEN_W-1];
			dm_in[j]  = diff[LEN_W-1] ? (~diff + 1'b1) : diff;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int j = 0; j < NAXES; j++) begin
				s_q[j]   <= in_data[j*COORD_W +: COORD_W];
				e_q[j]   <= in_data[(j+NAXES)*COORD_W +: COORD_W];
				dm_q[j]  <= dm_in[j];
				neg_q[j] <= neg_in[j];
			end
		end
	end

	assign mul_a = dm_q[cmd.axis];
	assign mul_b = cmd.mul_sq ? dm_q[cmd.axis] : {2'b00, st_eff};

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sum_q <= '0;
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + prod_s1;
		end
	end

	lpi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_start),
		.rad    (sum_q),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	always_ff @(posedge clk) begin
		if (sq_done) begin
			len_q <= sq_root;
		end
	end

	assign dv_num = cmd.div_n ? NUM_W'(len_q) : prod_s1[NUM_W-1:0];
	assign dv_den = cmd.div_n ? {2'b00, st_eff} : len_q;

	lpi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dv_num),
		.den    (dv_den),
		.busy   (dv_busy),
		.done   (dv_done),
		.quo    (dv_quo),
		.rem    (dv_rem)
	);

	assign n_full = {1'b0, dv_quo} + {{LEN_W{1'b0}}, (dv_rem != '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q    <= '0;
			clip_q <= 1'b0;
		end else if (cmd.load) begin
			clip_q <= 1'b0;
		end else if (dv_done && cmd.div_n) begin
			if (n_full > (LEN_W+1)'(MAX_POINTS - 1)) begin
				n_q    <= N_W'(MAX_POINTS - 1);
				clip_q <= 1'b1;
			end else begin
				n_q <= n_full[N_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dv_done && !cmd.div_n) begin
			qt_q[cmd.axis] <= dv_quo;
			rt_q[cmd.axis] <= dv_rem;
		end
	end

	always_ff @(posedge clk) begin
		logic [LEN_W:0] rs;
		for (int j = 0; j < NAXES; j++) begin
			rs = {1'b0, r_q[j]} + {1'b0, rt_q[j]};
			if (cmd.acc_clr) begin
				off_q[j] <= '0;
				r_q[j]   <= '0;
			end else if (cmd.acc_step) begin
				if (rs >= {1'b0, len_q}) begin
					r_q[j]   <= LEN_W'(rs - {1'b0, len_q});
					off_q[j] <= off_q[j] + qt_q[j] + 1'b1;
				end else begin
					r_q[j]   <= rs[LEN_W-1:0];
					off_q[j] <= off_q[j] + qt_q[j];
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < NAXES; j++) begin
			pt[j] = neg_q[j] ? (s_q[j] + off_q[j][COORD_W-1:0])
				: (s_q[j] - off_q[j][COORD_W-1:0]);
		end
	end

	assign out_free = !ov_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			ou_q <= clip_q;
			case (cmd.emit_sel)
				EM_START: begin
					od_q <= {s_q[2], s_q[1], s_q[0]};
					ol_q <= 1'b0;
				end
				EM_POINT: begin
					od_q <= {pt[2], pt[1], pt[0]};
					ol_q <= 1'b0;
				end
				default: begin
					od_q <= {e_q[2], e_q[1], e_q[0]};
					ol_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = ol_q;
	assign out_user  = ou_q;

	assign status.out_free   = out_free;
	assign status.sqrt_done  = sq_done;
	assign status.div_done   = dv_done;
	assign status.len_zero   = (len_q == '0);
	assign status.n          = n_q;
	assign status.clip       = clip_q;
	assign status.units_busy = sq_busy || dv_busy;

endmodule

>>> hdl/lpi_ctrl.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lpi_ctrl
// Controller: sequences the squares, root, divisions and point emission.
// -----------------------------------------------------------------------------
module lpi_ctrl import lpi_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output cmd_t    cmd,
	input  status_t status
);

	state_t         state_q;
	state_t         state_d;
	logic [1:0]     cnt_q;
	logic [1:0]     cnt_d;
	logic [N_W-1:0] k_q;
	logic [N_W-1:0] k_d;
	logic [N_W:0]   k_next;

	assign in_ready = (state_q == ST_IDLE);
	assign k_next   = {1'b0, k_q} + 1'b1;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					state_d  = ST_SQR;
				end
			end
			ST_SQR: begin
				cmd.mul_sq  = 1'b1;
				cmd.axis    = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
				cmd.sum_add = (cnt_q != 2'd0);
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == 2'd3) begin
					state_d = ST_RT_GO;
				end
			end
			ST_RT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_RT_WAIT;
			end
			ST_RT_WAIT: begin
				if (status.sqrt_done) begin
					state_d = ST_ND_GO;
				end
			end
			ST_ND_GO: begin
				cmd.div_n = 1'b1;
				if (status.len_zero) begin
					state_d = ST_E_END;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_ND_WAIT;
				end
			end
			ST_ND_WAIT: begin
				cmd.div_n = 1'b1;
				if (status.div_done) begin
					cnt_d   = '0;
					state_d = ST_AX_MUL;
				end
			end
			ST_AX_MUL: begin
				cmd.axis = cnt_q;
				state_d  = ST_AX_GO;
			end
			ST_AX_GO: begin
				cmd.axis      = cnt_q;
				cmd.div_start = 1'b1;
				state_d       = ST_AX_WAIT;
			end
			ST_AX_WAIT: begin
				cmd.axis = cnt_q;
				if (status.div_done) begin
					if (cnt_q == 2'd2) begin
						state_d = ST_E_START;
					end else begin
						cnt_d   = cnt_q + 1'b1;
						state_d = ST_AX_MUL;
					end
				end
			end
			ST_E_START: begin
				cmd.acc_clr  = 1'b1;
				cmd.emit     = 1'b1;
				cmd.emit_sel = EM_START;
				if (status.out_free) begin
					k_d     = N_W'(1);
					state_d = (status.n > N_W'(1)) ? ST_STEP : ST_E_END;
				end
			end
			ST_STEP: begin
				cmd.acc_step = 1'b1;
				state_d      = ST_E_PT;
			end
			ST_E_PT: begin
				cmd.emit     = 1'b1;
				cmd.emit_sel = EM_POINT;
				if (status.out_free) begin
					k_d     = k_next[N_W-1:0];
					state_d = (k_next < {1'b0, status.n}) ? ST_STEP : ST_E_END;
				end
			end
			ST_E_END: begin
				cmd.emit     = 1'b1;
				cmd.emit_sel = EM_END;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			k_q     <= k_d;
		end
	end

endmodule

>>> hdl/line_path_interpolator.sv
`timescale 1ns / 1ps
// For a segment of nonzero length, the first point waits for the 33-step square root
// and four 64-step divisions on one shared divider. Segments are taken one at a time;
// the next segment is taken once the end point is loaded into the output register.
// Reset: arst_n clears the controller, the output valid and sets step_length to 1.0.
// -----------------------------------------------------------------------------
// line_path_interpolator
// Emits evenly spaced points along a 3-D segment in Q15.16 fixed point.
// -----------------------------------------------------------------------------
module line_path_interpolator import lpi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [STEP_W-1:0] cfg_wr_data,   // step_length
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [IN_W-1:0]   s_axis_tdata,  // start_x, start_y, start_z, end_x, end_y, end_z
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [OUT_W-1:0]  m_axis_tdata,  // point_x, point_y, point_z
	output logic              m_axis_tlast,
	output logic [0:0]        m_axis_tuser   // count_clipped
);

	cmd_t    cmd;
	status_t sts;

	lpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.status   (sts)
	);

	lpi_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_axis_tdata),
		.cmd         (cmd),
		.status      (sts),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.out_user    (m_axis_tuser[0])
	);

`ifndef SYNTHESIS
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !sts.units_busy)
		else $error("Arithmetic unit busy while a new segment can be taken.");

	a_clip_count: assert property (@(posedge clk) disable iff (!arst_n)
		sts.clip |-> (sts.n == N_W'(MAX_POINTS - 1)))
		else $error("Clipped segment without a saturated step count.");

	a_start_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !sts.units_busy)
		else $error("Divider started while a unit was busy.");
`endif

endmodule
